/* hw/rtl/lpcp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared types and constants for the lidar point to camera projection block.
// ----------------------------------------------------------------------------
package lpcp_pkg;

    // fixed point and field widths
    localparam int FRAC_BITS  = 16;
    localparam int PIXEL_BITS = 16;
    localparam int COEF_W     = 32;
    localparam int PT_W       = 24;
    localparam int NUM_COEF   = 12;
    localparam int CIDX_W     = 4;
    localparam int CR_W       = 23;
    localparam int LEVEL_W    = 8;

    // datapath widths
    localparam int PROD_W = COEF_W + PT_W;
    localparam int OFF_W  = COEF_W + FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;
    localparam int QB     = PIXEL_BITS + 1;
    localparam int DIV_W  = SUM_W + QB;
    localparam int CN_W   = CR_W + LEVEL_W;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORWARD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATERAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_RANGE = 2'd3;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [CIDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [PT_W-1:0]   point_x;
        logic signed [PT_W-1:0]   point_y;
        logic signed [PT_W-1:0]   point_z;
    } t_in_item;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pixel_col;
        logic signed [PIXEL_BITS-1:0] pixel_row;
        logic [LEVEL_W-1:0]           red_level;
        logic [LEVEL_W-1:0]           green_level;
    } t_out_item;

    typedef struct packed {
        logic [CR_W-1:0]        max_forward;
        logic [CR_W-1:0]        max_lateral;
        logic signed [PT_W-1:0] min_height;
        logic [CR_W-1:0]        colour_range;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

/* hw/rtl/lpcp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpcp_front
// Accepts items, drops points outside the crop box and loads to bad slots.
// ----------------------------------------------------------------------------
module lpcp_front (
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire lpcp_pkg::t_in_item i_item,
    input  wire lpcp_pkg::t_cfg     i_cfg,
    input  wire lpcp_pkg::t_q_status i_qstat,
    output logic                    o_push
);

    logic                         w_x_ok;
    logic                         w_y_ok;
    logic                         w_z_ok;
    logic [lpcp_pkg::PT_W-1:0]    w_abs_y;
    logic                         w_keep;

    // crop box test
    always_comb begin
        w_abs_y = i_item.point_y[lpcp_pkg::PT_W-1] ? lpcp_pkg::PT_W'(-i_item.point_y)
                                                  : i_item.point_y;
        w_x_ok  = !i_item.point_x[lpcp_pkg::PT_W-1] &&
                  (i_item.point_x[lpcp_pkg::CR_W-1:0] <= i_cfg.max_forward);
        w_y_ok  = w_abs_y <= {1'b0, i_cfg.max_lateral};
        w_z_ok  = i_item.point_z >= i_cfg.min_height;
    end

    // classify item
    always_comb begin
        if (i_item.mode == lpcp_pkg::MODE_POINT) begin
            w_keep = w_x_ok && w_y_ok && w_z_ok;
        end else begin
            w_keep = i_item.coef_index < lpcp_pkg::CIDX_W'(lpcp_pkg::NUM_COEF);
        end
    end

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full && w_keep;

endmodule
`default_nettype wire

/* hw/rtl/lpcp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpcp_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module lpcp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire lpcp_pkg::t_in_item  i_data,
    input  wire logic                i_pop,
    output lpcp_pkg::t_in_item       o_head,
    output lpcp_pkg::t_q_status      o_stat
);

    lpcp_pkg::t_in_item             r_mem [lpcp_pkg::QDEPTH];
    logic [lpcp_pkg::QPTR_W-1:0]    r_wr;
    logic [lpcp_pkg::QPTR_W-1:0]    r_rd;
    logic [lpcp_pkg::QPTR_W:0]      r_cnt;
    logic [lpcp_pkg::QPTR_W:0]      n_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == (lpcp_pkg::QPTR_W+1)'(lpcp_pkg::QDEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule
`default_nettype wire

/* hw/rtl/lpcp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpcp_back
// Coefficient store, matrix multiply, pipelined division and colour ramp.
// ----------------------------------------------------------------------------
module lpcp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lpcp_pkg::t_cfg      i_cfg,
    input  wire lpcp_pkg::t_in_item  i_head,
    input  wire lpcp_pkg::t_q_status i_qstat,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output lpcp_pkg::t_out_item      o_item
);

    typedef struct packed {
        logic                              valid;
        logic                              zero;
        logic                              qneg_u;
        logic                              qneg_v;
        logic                              sat_u;
        logic                              sat_v;
        logic [lpcp_pkg::SUM_W-1:0]        rem_u;
        logic [lpcp_pkg::SUM_W-1:0]        rem_v;
        logic [lpcp_pkg::SUM_W-1:0]        den;
        logic [lpcp_pkg::QB-1:0]           q_u;
        logic [lpcp_pkg::QB-1:0]           q_v;
        logic [lpcp_pkg::CN_W-1:0]         crem;
        logic [lpcp_pkg::CR_W-1:0]         cden;
        logic [lpcp_pkg::LEVEL_W-1:0]      cq;
        logic                              csat;
        logic                              cgt;
        logic                              crz;
    } t_dv;

    localparam int PMAX = (1 << (lpcp_pkg::PIXEL_BITS - 1)) - 1;

    logic                                   w_adv;
    logic signed [lpcp_pkg::COEF_W-1:0]     r_coef [lpcp_pkg::NUM_COEF];
    logic signed [lpcp_pkg::PT_W-1:0]       w_pt [3];

    // stage 1: products
    logic                                   r_s1_valid;
    logic signed [lpcp_pkg::PROD_W-1:0]     r_s1_prod [3][3];
    logic signed [lpcp_pkg::PROD_W-1:0]     n_s1_prod [3][3];
    logic signed [lpcp_pkg::OFF_W-1:0]      r_s1_off [3];
    logic signed [lpcp_pkg::OFF_W-1:0]      n_s1_off [3];
    logic [lpcp_pkg::CR_W-1:0]              r_s1_d;
    logic [lpcp_pkg::CR_W-1:0]              n_s1_d;
    logic [lpcp_pkg::CR_W-1:0]              r_s1_cr;

    // stage 2: pair sums
    logic                                   r_s2_valid;
    logic signed [lpcp_pkg::SUM_W-1:0]      r_s2_a [3];
    logic signed [lpcp_pkg::SUM_W-1:0]      r_s2_b [3];
    logic [lpcp_pkg::CN_W-1:0]              r_s2_n;
    logic                                   r_s2_gt;
    logic [lpcp_pkg::CR_W-1:0]              r_s2_cr;

    // stage 3: dot products
    logic                                   r_s3_valid;
    logic signed [lpcp_pkg::SUM_W-1:0]      r_s3_sum [3];
    logic [lpcp_pkg::CN_W-1:0]              r_s3_n;
    logic                                   r_s3_gt;
    logic [lpcp_pkg::CR_W-1:0]              r_s3_cr;

    // stage 4: magnitudes
    logic                                   r_s4_valid;
    logic [lpcp_pkg::SUM_W-1:0]             r_s4_mag [3];
    logic                                   r_s4_neg [3];
    logic [lpcp_pkg::CN_W-1:0]              r_s4_n;
    logic                                   r_s4_gt;
    logic [lpcp_pkg::CR_W-1:0]              r_s4_cr;

    // division steps
    t_dv                                    r_dv [lpcp_pkg::QB+1];
    t_dv                                    n_dv0;

    // output register
    logic                                   r_out_valid;
    lpcp_pkg::t_out_item                    r_out;
    lpcp_pkg::t_out_item                    n_out;

    function automatic logic signed [lpcp_pkg::PIXEL_BITS-1:0] sat_pixel(
        input logic neg, input logic sat, input logic [lpcp_pkg::QB-1:0] mag);
        logic signed [lpcp_pkg::PIXEL_BITS-1:0] res;
        if (!neg) begin
            if (sat || mag > lpcp_pkg::QB'(PMAX)) begin
                res = lpcp_pkg::PIXEL_BITS'(PMAX);
            end else begin
                res = mag[lpcp_pkg::PIXEL_BITS-1:0];
            end
        end else begin
            if (sat || mag > lpcp_pkg::QB'(PMAX + 1)) begin
                res = lpcp_pkg::PIXEL_BITS'(PMAX + 1);
            end else begin
                res = -mag[lpcp_pkg::PIXEL_BITS-1:0];
            end
        end
        return res;
    endfunction

    // whole pipeline moves when the output register can take a result
    assign w_adv = !r_out_valid || !i_stall;
    assign o_pop = w_adv && !i_qstat.empty;

    // coefficient store, written as loads leave the queue in order
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.mode == lpcp_pkg::MODE_LOAD) begin
            r_coef[i_head.coef_index] <= i_head.coef_value;
        end
    end

    // products and colour distance
    always_comb begin
        w_pt[0] = i_head.point_x;
        w_pt[1] = i_head.point_y;
        w_pt[2] = i_head.point_z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_s1_prod[r][c] = $signed(r_coef[r*4+c]) * $signed(w_pt[c]);
            end
            n_s1_off[r] = $signed({r_coef[r*4+3], {lpcp_pkg::FRAC_BITS{1'b0}}});
        end
        if (i_head.point_x[lpcp_pkg::CR_W-1:0] >= i_cfg.colour_range) begin
            n_s1_d = i_head.point_x[lpcp_pkg::CR_W-1:0] - i_cfg.colour_range;
        end else begin
            n_s1_d = i_cfg.colour_range - i_head.point_x[lpcp_pkg::CR_W-1:0];
        end
    end

    // stages 1 to 4
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_prod <= n_s1_prod;
            r_s1_off  <= n_s1_off;
            r_s1_d    <= n_s1_d;
            r_s1_cr   <= i_cfg.colour_range;
            for (int r = 0; r < 3; r++) begin
                r_s2_a[r] <= lpcp_pkg::SUM_W'(r_s1_prod[r][0]) +
                             lpcp_pkg::SUM_W'(r_s1_prod[r][1]);
                r_s2_b[r] <= lpcp_pkg::SUM_W'(r_s1_prod[r][2]) +
                             lpcp_pkg::SUM_W'(r_s1_off[r]);
                r_s3_sum[r] <= r_s2_a[r] + r_s2_b[r];
                r_s4_neg[r] <= r_s3_sum[r][lpcp_pkg::SUM_W-1];
                r_s4_mag[r] <= r_s3_sum[r][lpcp_pkg::SUM_W-1]
                               ? lpcp_pkg::SUM_W'(-r_s3_sum[r]) : r_s3_sum[r];
            end
            r_s2_n  <= {r_s1_d, {lpcp_pkg::LEVEL_W{1'b0}}} -
                       lpcp_pkg::CN_W'(r_s1_d);
            r_s2_gt <= r_s1_d > r_s1_cr;
            r_s2_cr <= r_s1_cr;
            r_s3_n  <= r_s2_n;
            r_s3_gt <= r_s2_gt;
            r_s3_cr <= r_s2_cr;
            r_s4_n  <= r_s3_n;
            r_s4_gt <= r_s3_gt;
            r_s4_cr <= r_s3_cr;
        end
    end

    // division entry: overflow checks
    always_comb begin
        n_dv0.valid  = r_s4_valid;
        n_dv0.zero   = r_s4_mag[2] == '0;
        n_dv0.qneg_u = r_s4_neg[0] ^ r_s4_neg[2];
        n_dv0.qneg_v = r_s4_neg[1] ^ r_s4_neg[2];
        n_dv0.sat_u  = lpcp_pkg::DIV_W'(r_s4_mag[0]) >= {r_s4_mag[2], {lpcp_pkg::QB{1'b0}}};
        n_dv0.sat_v  = lpcp_pkg::DIV_W'(r_s4_mag[1]) >= {r_s4_mag[2], {lpcp_pkg::QB{1'b0}}};
        n_dv0.rem_u  = r_s4_mag[0];
        n_dv0.rem_v  = r_s4_mag[1];
        n_dv0.den    = r_s4_mag[2];
        n_dv0.q_u    = '0;
        n_dv0.q_v    = '0;
        n_dv0.crem   = r_s4_n;
        n_dv0.cden   = r_s4_cr;
        n_dv0.cq     = '0;
        n_dv0.csat   = r_s4_n >= {r_s4_cr, {lpcp_pkg::LEVEL_W{1'b0}}};
        n_dv0.cgt    = r_s4_gt;
        n_dv0.crz    = r_s4_cr == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].valid <= 1'b0;
        end else if (w_adv) begin
            r_dv[0] <= n_dv0;
        end
    end

    // one quotient bit per stage, colour ramp in the first stages
    for (genvar j = 0; j < lpcp_pkg::QB; j++) begin : g_step
        localparam int K  = lpcp_pkg::QB - 1 - j;
        localparam int KC = (j < lpcp_pkg::LEVEL_W) ? (lpcp_pkg::LEVEL_W - 1 - j) : 0;
        t_dv                           n_st;
        logic [lpcp_pkg::DIV_W-1:0]    w_dsh;
        logic [lpcp_pkg::CN_W-1:0]     w_csh;

        always_comb begin
            n_st  = r_dv[j];
            w_dsh = lpcp_pkg::DIV_W'(r_dv[j].den) << K;
            w_csh = lpcp_pkg::CN_W'(r_dv[j].cden) << KC;
            if (lpcp_pkg::DIV_W'(r_dv[j].rem_u) >= w_dsh) begin
                n_st.rem_u = r_dv[j].rem_u - w_dsh[lpcp_pkg::SUM_W-1:0];
                n_st.q_u[K] = 1'b1;
            end
            if (lpcp_pkg::DIV_W'(r_dv[j].rem_v) >= w_dsh) begin
                n_st.rem_v = r_dv[j].rem_v - w_dsh[lpcp_pkg::SUM_W-1:0];
                n_st.q_v[K] = 1'b1;
            end
            if (j < lpcp_pkg::LEVEL_W && r_dv[j].crem >= w_csh) begin
                n_st.crem   = r_dv[j].crem - w_csh;
                n_st.cq[KC] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1].valid <= 1'b0;
            end else if (w_adv) begin
                r_dv[j+1] <= n_st;
            end
        end
    end

    // saturation and colour levels
    always_comb begin
        n_out.pixel_col = sat_pixel(r_dv[lpcp_pkg::QB].qneg_u, r_dv[lpcp_pkg::QB].sat_u,
                                    r_dv[lpcp_pkg::QB].q_u);
        n_out.pixel_row = sat_pixel(r_dv[lpcp_pkg::QB].qneg_v, r_dv[lpcp_pkg::QB].sat_v,
                                    r_dv[lpcp_pkg::QB].q_v);
        if (r_dv[lpcp_pkg::QB].crz) begin
            n_out.red_level   = '1;
            n_out.green_level = '0;
        end else begin
            n_out.red_level   = r_dv[lpcp_pkg::QB].csat ? '1 : r_dv[lpcp_pkg::QB].cq;
            if (r_dv[lpcp_pkg::QB].cgt) begin
                n_out.green_level = '0;
            end else begin
                n_out.green_level = '1 - r_dv[lpcp_pkg::QB].cq -
                                    lpcp_pkg::LEVEL_W'(r_dv[lpcp_pkg::QB].crem != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= o_pop && i_head.mode == lpcp_pkg::MODE_POINT;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_dv[lpcp_pkg::QB].valid && !r_dv[lpcp_pkg::QB].zero;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
`default_nettype wire

/* hw/rtl/lidar_point_camera_projection.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_point_camera_projection
// Crops lidar points, projects them through a loaded 3x4 matrix to pixels
// and colours them by distance.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     i_valid / o_stall           i_item  (t_in_item)
//  output    o_valid / i_stall           o_item  (t_out_item)
//  config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  one item per cycle when nothing stalls; a point that is taken passes
//  through the queue, four arithmetic stages, the divider entry, the
//  17 quotient bit stages and the output register
//  a four entry queue parts the front from the back, so the front keeps
//  taking items while a result waits; the back moves as one when the output
//  register is free or taken
//  synchronous active low reset clears control state; the coefficient store
//  is undefined until loaded
module lidar_point_camera_projection (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire lpcp_pkg::t_in_item                  i_item,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output lpcp_pkg::t_out_item                      o_item,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lpcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lpcp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lpcp_pkg::t_cfg       r_cfg;
    lpcp_pkg::t_q_status  w_qstat;
    lpcp_pkg::t_in_item   w_head;
    logic                 w_push;
    logic                 w_pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_forward  <= 23'd1638400;
            r_cfg.max_lateral  <= 23'd393216;
            r_cfg.min_height   <= -24'sd91750;
            r_cfg.colour_range <= 23'd1310720;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lpcp_pkg::CFG_MAX_FORWARD: begin
                    r_cfg.max_forward <= i_cfg_data[lpcp_pkg::CR_W-1:0];
                end
                lpcp_pkg::CFG_MAX_LATERAL: begin
                    r_cfg.max_lateral <= i_cfg_data[lpcp_pkg::CR_W-1:0];
                end
                lpcp_pkg::CFG_MIN_HEIGHT: begin
                    r_cfg.min_height <= i_cfg_data;
                end
                lpcp_pkg::CFG_COLOUR_RANGE: begin
                    r_cfg.colour_range <= i_cfg_data[lpcp_pkg::CR_W-1:0];
                end
            endcase
        end
    end

    // front: accept and classify
    lpcp_front u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push)
    );

    // queue between front and back
    lpcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (i_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    // back: store, project, divide, colour
    lpcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // checks
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue read while empty");

endmodule
`default_nettype wire
